[design/mau_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mau_pkg: shared types and constants of the modular arithmetic unit
// Operation codes, field widths, reset modulus and controller states.
// ---------------------------------------------------------------------------
package mau_pkg;

    localparam int MOD_WIDTH_DEF = 31;
    localparam int EXP_WIDTH_DEF = 63;
    localparam int RAW_WIDTH     = 64;
    localparam int OP_WIDTH      = 3;
    localparam int OPND_WIDTH    = 31;
    localparam longint unsigned MOD_RESET = 64'd1000000007;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_POW    = 3'd5,
        OP_NEG    = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_RED_RAW,
        ST_DISPATCH,
        ST_POW_STEP,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_DIV_MUL,
        ST_FINAL_MUL,
        ST_OUT
    } t_state;

    // Request to the serial modular reduction unit.
    typedef struct packed {
        logic start;
    } t_red_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_red_sts;

endpackage

[design/mau_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mau_if: valid/ready channels of the modular arithmetic unit
// Input item channel, result channel and modulus write channel.
// ---------------------------------------------------------------------------
interface mau_in_if #(
    parameter int EXP_WIDTH = mau_pkg::EXP_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [mau_pkg::OP_WIDTH-1:0]  op;
    logic signed [mau_pkg::RAW_WIDTH-1:0] raw_value;
    logic [mau_pkg::OPND_WIDTH-1:0] lhs;
    logic [mau_pkg::OPND_WIDTH-1:0] rhs;
    logic [EXP_WIDTH-1:0]          exponent;

    modport source  (output valid, op, raw_value, lhs, rhs, exponent, input ready);
    modport sink    (input valid, op, raw_value, lhs, rhs, exponent, output ready);
    modport monitor (input valid, ready, op, raw_value, lhs, rhs, exponent);
endinterface

interface mau_out_if;
    logic                           valid;
    logic                           ready;
    logic [mau_pkg::OPND_WIDTH-1:0] result;
    logic                           operand_error;

    modport source  (output valid, result, operand_error, input ready);
    modport sink    (input valid, result, operand_error, output ready);
    modport monitor (input valid, ready, result, operand_error);
endinterface

interface mau_cfg_if #(
    parameter int MOD_WIDTH = mau_pkg::MOD_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [MOD_WIDTH-1:0] data;

    modport source  (output valid, data, input ready);
    modport sink    (input valid, data, output ready);
    modport monitor (input valid, ready, data);
endinterface

[design/mau_serial_mod.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mau_serial_mod: bit-serial remainder of a wide unsigned value
// Shifts the dividend in one bit per cycle, MSB first, and keeps a running
// remainder below the modulus with one compare and subtract per bit.
// Optionally multiplies two residues first by shift-and-add over the
// multiplier bits, reducing after each step (one multiplier bit per cycle).
// ---------------------------------------------------------------------------
module mau_serial_mod
    import mau_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF,
    parameter int DIV_WIDTH = RAW_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_red_ctl             i_ctl,
    input  logic                 i_mul_mode,
    input  logic [DIV_WIDTH-1:0] i_dividend,
    input  logic [MOD_WIDTH-1:0] i_mul_a,
    input  logic [MOD_WIDTH-1:0] i_mul_b,
    input  logic [MOD_WIDTH-1:0] i_modulus,
    output t_red_sts             o_sts,
    output logic [MOD_WIDTH-1:0] o_rem
);

    localparam int CW = $clog2(DIV_WIDTH + 1);

    logic [DIV_WIDTH-1:0] r_shift, n_shift;
    logic [MOD_WIDTH-1:0] r_addend, n_addend;
    logic [MOD_WIDTH-1:0] r_rem, n_rem;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic                 r_mul, n_mul;

    logic [MOD_WIDTH:0]   w_dbl;
    logic [MOD_WIDTH:0]   w_dbl_red;
    logic [MOD_WIDTH+1:0] w_sum;
    logic [MOD_WIDTH-1:0] w_step;

    always_comb begin
        // rem*2 + bit, reduced once (rem < M so result < 2M)
        w_dbl = {r_rem, (r_mul ? 1'b0 : r_shift[DIV_WIDTH-1])};
        if (w_dbl >= {1'b0, i_modulus}) begin
            w_dbl_red = w_dbl - {1'b0, i_modulus};
        end else begin
            w_dbl_red = w_dbl;
        end
        // add multiplicand when multiplier bit set, reduce once more
        w_sum = {1'b0, w_dbl_red};
        if (r_mul && r_shift[DIV_WIDTH-1]) begin
            w_sum = {1'b0, w_dbl_red} + {2'b00, r_addend};
        end
        if (w_sum >= {2'b00, i_modulus}) begin
            w_step = MOD_WIDTH'(w_sum - {2'b00, i_modulus});
        end else begin
            w_step = MOD_WIDTH'(w_sum);
        end
    end

    always_comb begin
        n_shift  = r_shift;
        n_addend = r_addend;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_mul    = r_mul;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_rem  = '0;
            n_cnt  = CW'(DIV_WIDTH);
            n_mul  = i_mul_mode;
            if (i_mul_mode) begin
                // multiplier bits at the top of the shifter, zeros below
                n_shift  = {i_mul_b, {(DIV_WIDTH-MOD_WIDTH){1'b0}}};
                n_addend = i_mul_a;
                n_cnt    = CW'(MOD_WIDTH);
            end else begin
                n_shift  = i_dividend;
            end
        end else if (r_busy) begin
            n_rem   = w_step;
            n_shift = {r_shift[DIV_WIDTH-2:0], 1'b0};
            n_cnt   = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mul  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_mul  <= n_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_addend <= n_addend;
        r_rem    <= n_rem;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule

[design/modular_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modular_arithmetic_unit_top: integer arithmetic modulo a runtime modulus
//
// Usage: write the modulus on the cfg channel while idle (reset value is
// 1000000007). Present one item on the in channel; it is taken when the unit
// is idle. One result item follows on the out channel. A single bit-serial
// reduce unit does all reductions and multiplies, one bit per cycle: both
// operands are reduced first, the reduce op then also reduces the raw value,
// add/sub/neg are formed from the reduced operands, mul takes one multiply,
// pow takes up to EXP_WIDTH steps of a multiply (when the exponent bit is
// set) and a square, and div takes up to MOD_WIDTH such steps and one more
// multiply. Pow ends early once the exponent runs out.
// The next item is accepted when the result has been transferred; a stalled
// receiver holds the result and the unit. Reset returns to idle and restores
// the reset modulus.
// ---------------------------------------------------------------------------
module modular_arithmetic_unit_top
    import mau_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mau_in_if.sink     i_in,
    mau_out_if.source  o_out,
    mau_cfg_if.sink    i_cfg
);

    localparam int EW  = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
    localparam int ECW = $clog2(EW + 1);

    t_state r_state, n_state;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [OP_WIDTH-1:0]  r_op;
    logic [RAW_WIDTH-1:0] r_raw;
    logic [OPND_WIDTH-1:0] r_lhs, r_rhs;
    logic [EW-1:0]        r_exp, n_exp;
    logic [ECW-1:0]       r_ecnt, n_ecnt;
    logic [MOD_WIDTH-1:0] r_a, n_a, r_b, n_b, r_acc, n_acc, r_sq, n_sq;
    logic [OPND_WIDTH-1:0] r_res, n_res;
    logic                 r_err, n_err;
    logic                 r_neg, n_neg;

    t_red_ctl             w_ctl;
    t_red_sts             w_sts;
    logic                 w_mul_mode;
    logic [RAW_WIDTH-1:0] w_div;
    logic [MOD_WIDTH-1:0] w_ma, w_mb, w_rem;
    logic                 w_mod_zero, w_bad_l, w_bad_r;
    logic [MOD_WIDTH:0]   w_addsum;
    logic [MOD_WIDTH-1:0] w_add, w_sub, w_neg, w_raw_res;
    logic [RAW_WIDTH-1:0] w_mag;
    logic [MOD_WIDTH-1:0] w_one;

    assign w_mod_zero = (r_mod == '0);
    assign w_bad_l = (33'(r_lhs) >= 33'(r_mod));
    assign w_bad_r = (33'(r_rhs) >= 33'(r_mod));
    assign w_one   = (r_mod == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
    assign w_mag   = r_raw[RAW_WIDTH-1] ? (~r_raw + 1'b1) : r_raw;

    always_comb begin
        w_addsum = {1'b0, r_a} + {1'b0, r_b};
        if (w_addsum >= {1'b0, r_mod}) begin
            w_add = MOD_WIDTH'(w_addsum - {1'b0, r_mod});
        end else begin
            w_add = MOD_WIDTH'(w_addsum);
        end
        w_sub     = (r_a >= r_b) ? (r_a - r_b) : (r_a + r_mod - r_b);
        w_neg     = (r_a == '0) ? '0 : (r_mod - r_a);
        w_raw_res = (r_neg && w_rem != '0) ? (r_mod - w_rem) : w_rem;
    end

    mau_serial_mod #(
        .MOD_WIDTH (MOD_WIDTH),
        .DIV_WIDTH (RAW_WIDTH)
    ) u_red (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_mul_mode (w_mul_mode),
        .i_dividend (w_div),
        .i_mul_a    (w_ma),
        .i_mul_b    (w_mb),
        .i_modulus  (r_mod),
        .o_sts      (w_sts),
        .o_rem      (w_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_RED_A;
                end
            end
            ST_RED_A: begin
                if (w_mod_zero) begin
                    n_state = ST_OUT;
                end else if (w_sts.done) begin
                    n_state = ST_RED_B;
                end
            end
            ST_RED_B: begin
                if (w_sts.done) begin
                    n_state = (r_op == OP_REDUCE) ? ST_RED_RAW : ST_DISPATCH;
                end
            end
            ST_RED_RAW: begin
                if (w_sts.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_DISPATCH: begin
                priority case (r_op)
                    OP_MUL:  n_state = ST_FINAL_MUL;
                    OP_POW:  n_state = ST_POW_STEP;
                    OP_DIV:  n_state = (r_b == '0) ? ST_OUT : ST_POW_STEP;
                    default: n_state = ST_OUT;
                endcase
            end
            ST_POW_STEP: begin
                if (r_ecnt == '0 || r_exp == '0) begin
                    n_state = (r_op == OP_DIV) ? ST_DIV_MUL : ST_OUT;
                end else if (r_exp[0]) begin
                    n_state = ST_POW_MUL;
                end else begin
                    n_state = ST_POW_SQR;
                end
            end
            ST_POW_MUL: begin
                if (w_sts.done) begin
                    n_state = ST_POW_SQR;
                end
            end
            ST_POW_SQR: begin
                if (w_sts.done) begin
                    n_state = ST_POW_STEP;
                end
            end
            ST_DIV_MUL, ST_FINAL_MUL: begin
                if (w_sts.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // start pulse for the serial unit on entry to each reducing state
    always_comb begin
        w_ctl.start = 1'b0;
        w_mul_mode  = 1'b0;
        w_div       = '0;
        w_ma        = r_a;
        w_mb        = r_b;
        unique case (n_state)
            ST_RED_A: w_div = RAW_WIDTH'(i_in.lhs);
            ST_RED_B: w_div = RAW_WIDTH'(r_rhs);
            ST_RED_RAW: w_div = w_mag;
            ST_POW_MUL: begin
                w_mul_mode = 1'b1;
                w_ma = r_acc;
                w_mb = r_sq;
            end
            ST_POW_SQR: begin
                w_mul_mode = 1'b1;
                w_ma = (r_state == ST_POW_MUL) ? r_sq : r_sq;
                w_mb = r_sq;
            end
            ST_DIV_MUL: begin
                w_mul_mode = 1'b1;
                w_ma = r_a;
                w_mb = r_acc;
            end
            ST_FINAL_MUL: begin
                w_mul_mode = 1'b1;
            end
            default: ;
        endcase
        if (n_state != r_state || (r_state == ST_IDLE && n_state == ST_RED_A)) begin
            w_ctl.start = (n_state == ST_RED_A && r_state == ST_IDLE)
                       || (n_state == ST_RED_B) || (n_state == ST_RED_RAW)
                       || (n_state == ST_POW_MUL) || (n_state == ST_POW_SQR)
                       || (n_state == ST_DIV_MUL) || (n_state == ST_FINAL_MUL);
        end
        if (r_state == ST_IDLE && n_state == ST_RED_A) begin
            w_div = RAW_WIDTH'(i_in.lhs);
        end
    end

    // datapath updates
    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_sq   = r_sq;
        n_exp  = r_exp;
        n_ecnt = r_ecnt;
        n_res  = r_res;
        n_err  = r_err;
        n_neg  = r_neg;
        unique case (r_state)
            ST_IDLE: begin
                n_neg = i_in.raw_value[RAW_WIDTH-1];
            end
            ST_RED_A: begin
                if (w_mod_zero) begin
                    n_res = '0;
                    n_err = 1'b1;
                end else if (w_sts.done) begin
                    n_a = w_rem;
                end
            end
            ST_RED_B: begin
                if (w_sts.done) begin
                    n_b = w_rem;
                end
            end
            ST_RED_RAW: begin
                if (w_sts.done) begin
                    n_res = OPND_WIDTH'(w_raw_res);
                    n_err = 1'b0;
                end
            end
            ST_DISPATCH: begin
                n_acc = w_one;
                n_err = 1'b0;
                n_res = '0;
                priority case (r_op)
                    OP_ADD: begin
                        n_res = OPND_WIDTH'(w_add);
                        n_err = w_bad_l || w_bad_r;
                    end
                    OP_SUB: begin
                        n_res = OPND_WIDTH'(w_sub);
                        n_err = w_bad_l || w_bad_r;
                    end
                    OP_MUL: n_err = w_bad_l || w_bad_r;
                    OP_DIV: begin
                        n_err  = w_bad_l || w_bad_r;
                        n_sq   = r_b;
                        n_exp  = (r_mod >= MOD_WIDTH'(2)) ?
                                 EW'(r_mod - MOD_WIDTH'(2)) : '0;
                        n_ecnt = ECW'(MOD_WIDTH);
                    end
                    OP_POW: begin
                        n_err  = w_bad_l;
                        n_sq   = r_a;
                        n_ecnt = ECW'(EXP_WIDTH);
                    end
                    OP_NEG: begin
                        n_res = OPND_WIDTH'(w_neg);
                        n_err = w_bad_l;
                    end
                    default: ;
                endcase
            end
            ST_POW_STEP: begin
                if (r_ecnt == '0) begin
                    n_res = OPND_WIDTH'(r_acc);
                end else if (r_exp == '0) begin
                    n_ecnt = '0;
                    n_res  = OPND_WIDTH'(r_acc);
                end
            end
            ST_POW_MUL: begin
                if (w_sts.done) begin
                    n_acc = w_rem;
                end
            end
            ST_POW_SQR: begin
                if (w_sts.done) begin
                    n_sq   = w_rem;
                    n_exp  = {1'b0, r_exp[EW-1:1]};
                    n_ecnt = r_ecnt - 1'b1;
                end
            end
            ST_DIV_MUL, ST_FINAL_MUL: begin
                if (w_sts.done) begin
                    n_res = OPND_WIDTH'(w_rem);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mod   <= MOD_WIDTH'(MOD_RESET);
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_mod <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in.valid) begin
            r_op  <= i_in.op;
            r_raw <= i_in.raw_value;
            r_lhs <= i_in.lhs;
            r_rhs <= i_in.rhs;
            r_exp <= EW'(i_in.exponent);
        end else begin
            r_exp <= n_exp;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_ecnt <= n_ecnt;
        r_res  <= n_res;
        r_err  <= n_err;
        r_neg  <= n_neg;
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = (r_state == ST_OUT);
    assign o_out.result        = r_res;
    assign o_out.operand_error = r_err;

endmodule
